// File: rtl/rfdke_pkg.sv
package rfdke_pkg;

    // frame geometry
    localparam int FRAME_BYTES = 18;
    localparam int FRAME_W     = FRAME_BYTES * 8;
    localparam int CNT_W       = 5;

    // default depth of the decode queue
    localparam int QUEUE_DEPTH_DEF = 2;

    // channel and field widths
    localparam int CH_W      = 11;
    localparam int KEY_W     = 16;
    localparam int OUT_DATA_W = 160;
    localparam int IN_DATA_W  = 24;

    // register reset values
    localparam logic [CH_W-1:0] CHANNEL_OFFSET_RST = 11'd1024;
    localparam logic [CH_W-1:0] STICK_LIMIT_RST    = 11'd700;

    // request kinds on the input tuser
    typedef enum logic [1:0] {
        REQ_BYTE  = 2'd0,
        REQ_IDLE  = 2'd1,
        REQ_QUERY = 2'd2
    } req_type_t;

    // result status on the output tuser
    typedef enum logic [1:0] {
        STAT_ACCEPT = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_QUERY  = 2'd2
    } status_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_CHANNEL_OFFSET = 1'b0,
        CFG_STICK_LIMIT    = 1'b1
    } cfg_index_t;

    // work handed from front to back: a whole frame or a key query mask
    typedef struct packed {
        logic               is_query;
        logic [FRAME_W-1:0] payload;
    } q_entry_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

endpackage

// File: rtl/rfdke_front.sv
module rfdke_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_req,
    input  logic [7:0]           in_byte,
    input  logic [15:0]          in_mask,
    input  rfdke_pkg::q_status_t q_stat,
    output logic                 push,
    output rfdke_pkg::q_entry_t  push_entry
);

    logic [7:0]                      store_reg [rfdke_pkg::FRAME_BYTES];
    logic [rfdke_pkg::CNT_W-1:0]     count_reg;
    logic [rfdke_pkg::CNT_W-1:0]     count_next;
    logic [rfdke_pkg::FRAME_W-1:0]   frame_word;
    logic                            accept;
    logic                            frame_full;
    rfdke_pkg::req_type_t            req;

    assign req        = rfdke_pkg::req_type_t'(in_req);
    assign in_ready   = !q_stat.full;
    assign accept     = in_valid && in_ready;
    assign frame_full = (count_reg == rfdke_pkg::CNT_W'(rfdke_pkg::FRAME_BYTES));

    // frame store viewed as one word, byte 0 lowest
    for (genvar i = 0; i < rfdke_pkg::FRAME_BYTES; i++) begin : g_frame
        assign frame_word[i*8 +: 8] = store_reg[i];
    end

    // byte count, saturating one past a full frame
    always_comb begin
        count_next = count_reg;
        if (accept) begin
            case (req)
                rfdke_pkg::REQ_BYTE: begin
                    if (count_reg <= rfdke_pkg::CNT_W'(rfdke_pkg::FRAME_BYTES)) begin
                        count_next = count_reg + 1'b1;
                    end
                end
                rfdke_pkg::REQ_IDLE:  count_next = '0;
                rfdke_pkg::REQ_QUERY: count_next = count_reg;
                default:              count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // frame store write
    always_ff @(posedge aclk) begin
        if (accept && req == rfdke_pkg::REQ_BYTE &&
            count_reg < rfdke_pkg::CNT_W'(rfdke_pkg::FRAME_BYTES)) begin
            store_reg[count_reg] <= in_byte;
        end
    end

    // classify: full frame on idle, or key query, goes to the back
    always_comb begin
        push                = 1'b0;
        push_entry.is_query = 1'b0;
        push_entry.payload  = frame_word;
        case (req)
            rfdke_pkg::REQ_IDLE: begin
                push = accept && frame_full;
            end
            rfdke_pkg::REQ_QUERY: begin
                push                = accept;
                push_entry.is_query = 1'b1;
                push_entry.payload  = rfdke_pkg::FRAME_W'(in_mask);
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/rfdke_queue.sv
module rfdke_queue #(
    parameter int QUEUE_DEPTH = rfdke_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  rfdke_pkg::q_entry_t  push_entry,
    input  logic                 pop,
    output rfdke_pkg::q_entry_t  head,
    output rfdke_pkg::q_status_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rfdke_pkg::q_entry_t mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_reg, wr_next;
    logic [PTR_W-1:0]    rd_reg, rd_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign stat.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.valid = (cnt_reg != '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.valid;
    assign head       = mem_reg[rd_reg];

    // pointer and fill count
    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push) begin
            wr_next = (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_next = (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/rfdke_back.sv
module rfdke_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [0:0]                          cfg_index,
    input  logic [rfdke_pkg::CH_W-1:0]          cfg_data,
    input  rfdke_pkg::q_status_t                q_stat,
    input  rfdke_pkg::q_entry_t                 head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          out_status,
    output logic [rfdke_pkg::OUT_DATA_W-1:0]    out_data
);

    localparam int CH_W  = rfdke_pkg::CH_W;
    localparam int KEY_W = rfdke_pkg::KEY_W;

    logic [CH_W-1:0]                   offset_reg;
    logic [CH_W-1:0]                   limit_reg;
    logic [KEY_W-1:0]                  keys_now_reg, keys_now_next;
    logic [KEY_W-1:0]                  keys_chg_reg, keys_chg_next;
    logic [KEY_W-1:0]                  keys_used_reg, keys_used_next;
    logic                              out_valid_reg;
    logic [1:0]                        status_reg, status_next;
    logic [rfdke_pkg::OUT_DATA_W-1:0]  data_reg, data_next;

    logic [rfdke_pkg::FRAME_W-1:0]     f;
    logic [CH_W-1:0]                   raw [4];
    logic signed [CH_W:0]              diff [4];
    logic [CH_W:0]                     mag [4];
    logic [3:0]                        over;
    logic [1:0]                        sw1, sw2;
    logic                              bad;
    logic [KEY_W-1:0]                  key_new, key_chg, mask;
    logic [KEY_W-1:0]                  dial, mouse_a, mouse_b;
    logic                              held, once;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= rfdke_pkg::CHANNEL_OFFSET_RST;
            limit_reg  <= rfdke_pkg::STICK_LIMIT_RST;
        end else if (cfg_valid) begin
            case (rfdke_pkg::cfg_index_t'(cfg_index))
                rfdke_pkg::CFG_CHANNEL_OFFSET: offset_reg <= cfg_data;
                rfdke_pkg::CFG_STICK_LIMIT:    limit_reg  <= cfg_data;
                default:                       offset_reg <= offset_reg;
            endcase
        end
    end

    // take the head when the output register is free or drains
    assign pop       = q_stat.valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_status = status_reg;
    assign out_data  = data_reg;

    // channel slicing and range check
    assign f      = head.payload;
    assign raw[0] = f[10:0];
    assign raw[1] = f[21:11];
    assign raw[2] = f[32:22];
    assign raw[3] = f[43:33];
    assign sw1    = f[45:44];
    assign sw2    = f[47:46];

    for (genvar i = 0; i < 4; i++) begin : g_stick
        assign diff[i] = $signed({1'b0, raw[i]}) - $signed({1'b0, offset_reg});
        assign mag[i]  = diff[i][CH_W] ? (CH_W+1)'(-diff[i]) : diff[i];
        assign over[i] = (mag[i] > {1'b0, limit_reg});
    end

    assign bad     = (|over) || (sw1 == 2'd0) || (sw2 == 2'd0);
    assign key_new = f[127:112];
    assign key_chg = key_new ^ keys_now_reg;
    assign dial    = f[143:128] - KEY_W'(offset_reg);
    assign mouse_a = KEY_W'(0) - f[63:48];
    assign mouse_b = KEY_W'(0) - f[79:64];

    // key query flags
    assign mask = f[15:0];
    assign held = |(keys_now_reg & mask);
    assign once = held && (|(keys_chg_reg & mask)) && !(|(keys_used_reg & mask));

    // result word and key state update
    always_comb begin
        keys_now_next  = keys_now_reg;
        keys_chg_next  = keys_chg_reg;
        keys_used_next = keys_used_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        if (pop) begin
            if (head.is_query) begin
                status_next = rfdke_pkg::STAT_QUERY;
                data_next   = {14'd0, once, held, keys_now_reg, 128'd0};
                if (!held) begin
                    keys_used_next = keys_used_reg & ~mask;
                end else if (once) begin
                    keys_used_next = keys_used_reg | mask;
                end
            end else begin
                keys_chg_next = key_chg;
                if (bad) begin
                    keys_now_next = '0;
                    status_next   = rfdke_pkg::STAT_REJECT;
                    data_next     = {key_chg, 144'd0};
                end else begin
                    keys_now_next = key_new;
                    status_next   = rfdke_pkg::STAT_ACCEPT;
                    data_next     = {key_chg, key_new, f[95:80], mouse_b, mouse_a,
                                     f[111:96], sw2, sw1, dial,
                                     diff[3][CH_W-1:0], diff[2][CH_W-1:0],
                                     diff[1][CH_W-1:0], diff[0][CH_W-1:0]};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keys_now_reg  <= '0;
            keys_chg_reg  <= '0;
            keys_used_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            keys_now_reg  <= keys_now_next;
            keys_chg_reg  <= keys_chg_next;
            keys_used_reg <= keys_used_next;
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        data_reg   <= data_next;
    end

endmodule

// File: rtl/remote_frame_decoder_key_edge_unit.sv
// Remote-control frame decoder with key edge tracking.
// Input stream (s_*): one word per received serial byte (tuser = 0), per
// idle-line event (tuser = 1) or per key query (tuser = 2). An idle event
// after exactly 18 bytes decodes the frame; any other burst length is
// dropped with no result. Queries answer held / pressed-once flags.
// Result stream (m_*): one word per decoded frame or query; tuser carries
// the status, tdata the sticks, dial, switches, mouse, keys and key flags.
// Config channel: cfg_index selects channel offset (0) or stick limit (1);
// write only while the block is idle. cfg_ready is always high.
// Path: a frame or query word passes through the queue, then the result
// register that drives m_tvalid. Throughput: one word per cycle while the
// queue is not full, set by the decode stage behind the front queue.
// Stall: the result register holds while m_tready is low; the front keeps
// taking words until the QUEUE_DEPTH-entry queue fills, then drops s_tready.
// Reset (aresetn low, synchronous): byte count, key state and queue clear,
// registers return to offset 1024 and limit 700.
module remote_frame_decoder_key_edge_unit #(
    parameter int QUEUE_DEPTH = rfdke_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // data_byte [7:0], key_mask [23:8]
    input  logic [rfdke_pkg::IN_DATA_W-1:0]    s_tdata,
    // req_type [1:0]
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // stick_right_h [10:0], stick_right_v [21:11], stick_left_h [32:22],
    // stick_left_v [43:33], dial [59:44], switches_buttons [79:60],
    // mouse_first_axis [95:80], mouse_second_axis [111:96],
    // mouse_wheel [127:112], key_bits [143:128], key_flags [159:144]
    output logic [rfdke_pkg::OUT_DATA_W-1:0]   m_tdata,
    // status [1:0]
    output logic [1:0]                         m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [0:0]                         cfg_index,
    input  logic [rfdke_pkg::CH_W-1:0]         cfg_data
);

    rfdke_pkg::q_status_t q_stat;
    rfdke_pkg::q_entry_t  push_entry;
    rfdke_pkg::q_entry_t  head;
    logic                 push;
    logic                 pop;

    assign cfg_ready = 1'b1;

    rfdke_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_req     (s_tuser),
        .in_byte    (s_tdata[7:0]),
        .in_mask    (s_tdata[23:8]),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    rfdke_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    rfdke_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_stat     (q_stat),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_data   (m_tdata)
    );

endmodule

// File: rtl/rfdke_checker.sv
module rfdke_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rfdke_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [1:0]                        m_tuser
);

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // query answers carry only keys and flags
    a_query_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rfdke_pkg::STAT_QUERY |-> m_tdata[127:0] == '0)
        else $error("query answer has frame fields set");

    // rejected frames carry only the change mask
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rfdke_pkg::STAT_REJECT |-> m_tdata[143:0] == '0)
        else $error("rejected frame has fields set");

    // pressed-once only when held
    a_once_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rfdke_pkg::STAT_QUERY && m_tdata[145] |-> m_tdata[144])
        else $error("pressed-once flag without held flag");

endmodule

bind remote_frame_decoder_key_edge_unit rfdke_checker u_rfdke_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
